[rtl/sosa_pkg.sv]
// shared types, codes and constants of the obstacle-avoidance sequencer
// no dependencies
`timescale 1ns / 1ps

package sosa_pkg;

    localparam int CollisionW = 9;
    localparam int MarginW    = 8;
    localparam int WaitW      = 10;
    localparam int DutyW      = 8;
    localparam int CountW     = 8;
    localparam int AngleW     = 8;
    localparam int CmdW       = 2;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 10;
    localparam int ProdW      = 16;

    localparam logic [CfgIdxW-1:0] REG_COLLISION  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MARGIN     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SCAN_SETTLE = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_LOOK_SETTLE = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DRIVE_DUTY  = 3'd4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_ECHO  = 1'b1;

    localparam logic [CmdW-1:0] CMD_STOP  = 2'd0;
    localparam logic [CmdW-1:0] CMD_FWD   = 2'd1;
    localparam logic [CmdW-1:0] CMD_LEFT  = 2'd2;
    localparam logic [CmdW-1:0] CMD_RIGHT = 2'd3;

    localparam logic signed [AngleW-1:0] ANGLE_CENTER = 8'sd0;
    localparam logic signed [AngleW-1:0] ANGLE_SCAN_L = 8'sd45;
    localparam logic signed [AngleW-1:0] ANGLE_SCAN_R = -8'sd45;
    localparam logic signed [AngleW-1:0] ANGLE_LOOK_L = 8'sd90;
    localparam logic signed [AngleW-1:0] ANGLE_LOOK_R = -8'sd90;

    localparam logic [ProdW-1:0] SOUND_DIV = 16'd58;

    localparam logic [CollisionW-1:0] COLLISION_RST   = 9'd20;
    localparam logic [MarginW-1:0]    MARGIN_RST      = 8'd20;
    localparam logic [WaitW-1:0]      SCAN_SETTLE_RST = 10'd200;
    localparam logic [WaitW-1:0]      LOOK_SETTLE_RST = 10'd500;
    localparam logic [DutyW-1:0]      DUTY_RST        = 8'd128;

    typedef enum logic [2:0] {
        JOB_START,
        JOB_SCAN,
        JOB_LOOK_LEFT,
        JOB_LOOK_RIGHT,
        JOB_TURN_BEGIN,
        JOB_TURN_STEP,
        JOB_TURN_END
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [1:0]  slot;
        logic        turn_left;
    } job_t;

    typedef struct packed {
        logic [CollisionW-1:0] collision_cm;
        logic [MarginW-1:0]    clear_margin_cm;
        logic [WaitW-1:0]      scan_settle_ms;
        logic [WaitW-1:0]      look_settle_ms;
        logic [DutyW-1:0]      drive_duty;
    } cfg_t;

    typedef struct packed {
        logic signed [AngleW-1:0] servo_angle;
        logic [CmdW-1:0]          motor_cmd;
        logic [DutyW-1:0]         motor_duty;
        logic [WaitW-1:0]         wait_ms;
        logic                     do_measure;
        logic                     last_of_run;
    } result_t;

    function automatic logic signed [AngleW-1:0] scan_angle(input logic [1:0] slot);
        logic signed [AngleW-1:0] a;
        case (slot)
            2'd1:    a = ANGLE_SCAN_L;
            2'd3:    a = ANGLE_SCAN_R;
            default: a = ANGLE_CENTER;
        endcase
        return a;
    endfunction

endpackage

[rtl/sosa_front.sv]
// front end: accepts words, tracks the avoidance phase, classifies words into jobs,
// except echo words while idle; depends on sosa_pkg
`timescale 1ns / 1ps

module sosa_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [sosa_pkg::CountW-1:0]   s_echo_count,
    input  sosa_pkg::cfg_t                cfg,
    input  logic                          q_full,
    output logic                          push,
    output sosa_pkg::job_t                job
);
    import sosa_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SCAN,
        PH_LOOK_LEFT,
        PH_LOOK_RIGHT,
        PH_TURNING
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [1:0]          slot_reg, slot_next;
    logic [CountW-1:0]   left_echo_reg, left_echo_next;
    logic                turn_left_reg, turn_left_next;

    logic                accept;
    logic [ProdW-1:0]    echo64;
    logic [ProdW-1:0]    collide_lim;
    logic [ProdW-1:0]    clear_lim;
    logic                is_close;
    logic                is_clear;
    logic                turn_left_now;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign echo64      = {2'b00, s_echo_count, 6'b000000};
    assign collide_lim = ProdW'(cfg.collision_cm) * SOUND_DIV;
    assign clear_lim   = (ProdW'(cfg.collision_cm) + ProdW'(cfg.clear_margin_cm)) * SOUND_DIV;
    assign is_close    = echo64 < collide_lim;
    assign is_clear    = !(echo64 < clear_lim);
    assign turn_left_now = left_echo_reg > s_echo_count;

    always_comb begin
        phase_next     = phase_reg;
        slot_next      = slot_reg;
        left_echo_next = left_echo_reg;
        turn_left_next = turn_left_reg;
        push           = 1'b0;
        job.kind       = JOB_START;
        job.slot       = slot_reg;
        job.turn_left  = turn_left_reg;
        if (accept) begin
            if (s_req_type == REQ_START) begin
                phase_next = PH_SCAN;
                slot_next  = 2'd0;
                push       = 1'b1;
                job.kind   = JOB_START;
            end else begin
                case (phase_reg)
                    PH_SCAN: begin
                        push = 1'b1;
                        if (is_close) begin
                            phase_next = PH_LOOK_LEFT;
                            job.kind   = JOB_LOOK_LEFT;
                        end else begin
                            slot_next = slot_reg + 2'd1;
                            job.kind  = JOB_SCAN;
                            job.slot  = slot_reg + 2'd1;
                        end
                    end
                    PH_LOOK_LEFT: begin
                        push           = 1'b1;
                        left_echo_next = s_echo_count;
                        phase_next     = PH_LOOK_RIGHT;
                        job.kind       = JOB_LOOK_RIGHT;
                    end
                    PH_LOOK_RIGHT: begin
                        push           = 1'b1;
                        turn_left_next = turn_left_now;
                        phase_next     = PH_TURNING;
                        job.kind       = JOB_TURN_BEGIN;
                        job.turn_left  = turn_left_now;
                    end
                    PH_TURNING: begin
                        push = 1'b1;
                        if (is_clear) begin
                            phase_next = PH_SCAN;
                            slot_next  = 2'd0;
                            job.kind   = JOB_TURN_END;
                        end else begin
                            job.kind = JOB_TURN_STEP;
                        end
                    end
                    default: begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            slot_reg      <= 2'd0;
            left_echo_reg <= '0;
            turn_left_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            left_echo_reg <= left_echo_next;
            turn_left_reg <= turn_left_next;
        end
    end

endmodule

[rtl/sosa_queue.sv]
// two-entry job queue between front and back end
// depends on sosa_pkg
`timescale 1ns / 1ps

module sosa_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sosa_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output sosa_pkg::job_t  head_job
);
    import sosa_pkg::*;

    job_t        mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head_job  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/sosa_back.sv]
// back end: expands each job into one or two result words behind an output register
// depends on sosa_pkg
`timescale 1ns / 1ps

module sosa_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  sosa_pkg::cfg_t    cfg,
    input  logic              q_not_empty,
    input  sosa_pkg::job_t    q_job,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output sosa_pkg::result_t m_res
);
    import sosa_pkg::*;

    logic      valid_reg, valid_next;
    result_t   res_reg, res_next;
    logic      second_reg, second_next;
    job_t      held_reg, held_next;
    logic      load;
    job_t      cur_job;
    logic      cur_second;
    result_t   word;
    logic [CmdW-1:0] turn_cmd;

    assign load    = !valid_reg || m_ready;
    assign pop     = load && !second_reg && q_not_empty;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    assign cur_job    = second_reg ? held_reg : q_job;
    assign cur_second = second_reg;
    assign turn_cmd   = cur_job.turn_left ? CMD_LEFT : CMD_RIGHT;

    always_comb begin
        word.servo_angle = ANGLE_CENTER;
        word.motor_cmd   = CMD_FWD;
        word.wait_ms     = cfg.scan_settle_ms;
        word.do_measure  = 1'b1;
        word.last_of_run = 1'b1;
        case (cur_job.kind)
            JOB_START: begin
                word.motor_cmd = CMD_FWD;
            end
            JOB_SCAN: begin
                word.servo_angle = scan_angle(cur_job.slot);
            end
            JOB_LOOK_LEFT: begin
                word.servo_angle = ANGLE_LOOK_L;
                word.motor_cmd   = CMD_STOP;
                word.wait_ms     = cfg.look_settle_ms;
            end
            JOB_LOOK_RIGHT: begin
                word.servo_angle = ANGLE_LOOK_R;
                word.motor_cmd   = CMD_STOP;
                word.wait_ms     = cfg.look_settle_ms;
            end
            JOB_TURN_BEGIN: begin
                if (cur_second) begin
                    word.motor_cmd = turn_cmd;
                    word.wait_ms   = '0;
                end else begin
                    word.motor_cmd   = CMD_STOP;
                    word.do_measure  = 1'b0;
                    word.last_of_run = 1'b0;
                end
            end
            JOB_TURN_STEP: begin
                word.motor_cmd = turn_cmd;
                word.wait_ms   = '0;
            end
            JOB_TURN_END: begin
                if (!cur_second) begin
                    word.motor_cmd   = CMD_STOP;
                    word.wait_ms     = '0;
                    word.do_measure  = 1'b0;
                    word.last_of_run = 1'b0;
                end
            end
            default: begin
                word.motor_cmd = CMD_STOP;
            end
        endcase
        word.motor_duty = (word.motor_cmd == CMD_STOP) ? '0 : cfg.drive_duty;
    end

    always_comb begin
        valid_next  = valid_reg;
        res_next    = res_reg;
        second_next = second_reg;
        held_next   = held_reg;
        if (load) begin
            if (second_reg) begin
                valid_next  = 1'b1;
                res_next    = word;
                second_next = 1'b0;
            end else if (q_not_empty) begin
                valid_next  = 1'b1;
                res_next    = word;
                held_next   = q_job;
                second_next = (q_job.kind == JOB_TURN_BEGIN) || (q_job.kind == JOB_TURN_END);
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        held_reg <= held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

endmodule

[rtl/sonar_obstacle_avoid_sequencer.sv]
// top level of the sonar obstacle-avoidance sequencer: configuration registers and the
// front end, job queue and back end; depends on sosa_pkg, sosa_front, sosa_queue, sosa_back
`timescale 1ns / 1ps

// Each start request or echo word is classified by the front end in the cycle it is
// accepted and leaves a job in a two-entry queue; the back end turns a job into one
// result word per cycle while m_ready is high, through a registered output. Most
// words yield one result; the right look and the end of a turn yield two, so the
// sustained rate is set by the single output register. Echo words that arrive while
// idle are taken and dropped. Configuration is taken at any time through the cfg port
// (cfg_ready is always high) and should only change while no word is in flight.
module sonar_obstacle_avoid_sequencer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic [sosa_pkg::CountW-1:0]          s_echo_count,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sosa_pkg::AngleW-1:0]   m_servo_angle,
    output logic [sosa_pkg::CmdW-1:0]            m_motor_cmd,
    output logic [sosa_pkg::DutyW-1:0]           m_motor_duty,
    output logic [sosa_pkg::WaitW-1:0]           m_wait_ms,
    output logic                                 m_do_measure,
    output logic                                 m_last_of_run,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sosa_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [sosa_pkg::CfgDataW-1:0]        cfg_wdata
);
    import sosa_pkg::*;

    cfg_t     cfg_reg;
    logic     q_full;
    logic     q_not_empty;
    logic     push;
    logic     pop;
    job_t     push_job;
    job_t     head_job;
    result_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.collision_cm    <= COLLISION_RST;
            cfg_reg.clear_margin_cm <= MARGIN_RST;
            cfg_reg.scan_settle_ms  <= SCAN_SETTLE_RST;
            cfg_reg.look_settle_ms  <= LOOK_SETTLE_RST;
            cfg_reg.drive_duty      <= DUTY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_COLLISION:   cfg_reg.collision_cm    <= cfg_wdata[CollisionW-1:0];
                REG_MARGIN:      cfg_reg.clear_margin_cm <= cfg_wdata[MarginW-1:0];
                REG_SCAN_SETTLE: cfg_reg.scan_settle_ms  <= cfg_wdata[WaitW-1:0];
                REG_LOOK_SETTLE: cfg_reg.look_settle_ms  <= cfg_wdata[WaitW-1:0];
                REG_DRIVE_DUTY:  cfg_reg.drive_duty      <= cfg_wdata[DutyW-1:0];
                default: begin
                end
            endcase
        end
    end

    sosa_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_echo_count (s_echo_count),
        .cfg          (cfg_reg),
        .q_full       (q_full),
        .push         (push),
        .job          (push_job)
    );

    sosa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    sosa_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_job       (head_job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_res       (res)
    );

    assign m_servo_angle = res.servo_angle;
    assign m_motor_cmd   = res.motor_cmd;
    assign m_motor_duty  = res.motor_duty;
    assign m_wait_ms     = res.wait_ms;
    assign m_do_measure  = res.do_measure;
    assign m_last_of_run = res.last_of_run;

endmodule

[test/sonar_obstacle_avoid_sequencer_test.sv]
// testbench for sonar_obstacle_avoid_sequencer: start and echo words are pushed through
// the block and every result word is checked against an in-bench model of the avoidance
// sequence; depends on sosa_pkg and the rtl of the block
`timescale 1ns / 1ps

module sonar_obstacle_avoid_sequencer_test;

    import sosa_pkg::*;

    localparam int CycleLimit = 600000;

    typedef enum logic [2:0] {
        NAV_IDLE,
        NAV_SCAN,
        NAV_LOOK_LEFT,
        NAV_LOOK_RIGHT,
        NAV_TURNING
    } nav_phase_t;

    typedef struct packed {
        logic              req;
        logic [CountW-1:0] count;
    } sonar_word_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_req_type = 1'b0;
    logic [CountW-1:0]        s_echo_count = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [AngleW-1:0] m_servo_angle;
    logic [CmdW-1:0]          m_motor_cmd;
    logic [DutyW-1:0]         m_motor_duty;
    logic [WaitW-1:0]         m_wait_ms;
    logic                     m_do_measure;
    logic                     m_last_of_run;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CfgIdxW-1:0]       cfg_index = '0;
    logic [CfgDataW-1:0]      cfg_wdata = '0;

    // model of the block's settings and sequencing state
    logic [CollisionW-1:0] cfg_collision = COLLISION_RST;
    logic [MarginW-1:0]    cfg_margin = MARGIN_RST;
    logic [WaitW-1:0]      cfg_scan_settle = SCAN_SETTLE_RST;
    logic [WaitW-1:0]      cfg_look_settle = LOOK_SETTLE_RST;
    logic [DutyW-1:0]      cfg_duty = DUTY_RST;
    nav_phase_t            nav_phase = NAV_IDLE;
    logic [1:0]            nav_slot = '0;
    logic [CountW-1:0]     left_count = '0;
    logic                  turn_left_q = 1'b0;

    sonar_word_t outgoing_words[$];
    result_t     expected_moves[$];
    result_t     want_move;
    sonar_word_t next_word;
    int          words_queued = 0;
    int          words_taken = 0;
    int          fault_count = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          stall_left = 0;
    int          stall_requests = 0;
    int          stall_served = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    sonar_obstacle_avoid_sequencer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_echo_count  (s_echo_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_servo_angle (m_servo_angle),
        .m_motor_cmd   (m_motor_cmd),
        .m_motor_duty  (m_motor_duty),
        .m_wait_ms     (m_wait_ms),
        .m_do_measure  (m_do_measure),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [AngleW-1:0] slot_angle(input logic [1:0] slot);
        if (slot == 2'd1) return ANGLE_SCAN_L;
        if (slot == 2'd3) return ANGLE_SCAN_R;
        return ANGLE_CENTER;
    endfunction

    function automatic void push_move(input logic signed [AngleW-1:0] angle,
                                      input logic [CmdW-1:0] cmd,
                                      input logic [WaitW-1:0] settle,
                                      input logic meas, input logic last);
        result_t r;
        r.servo_angle = angle;
        r.motor_cmd   = cmd;
        r.motor_duty  = (cmd == CMD_STOP) ? '0 : cfg_duty;
        r.wait_ms     = settle;
        r.do_measure  = meas;
        r.last_of_run = last;
        expected_moves.push_back(r);
    endfunction

    function automatic void predict_motion(input logic req, input logic [CountW-1:0] count);
        int unsigned     echo_scaled;
        logic [CmdW-1:0] turn_cmd;
        echo_scaled = 64 * count;
        if (req == REQ_START) begin
            nav_phase = NAV_SCAN;
            nav_slot  = '0;
            push_move(ANGLE_CENTER, CMD_FWD, cfg_scan_settle, 1'b1, 1'b1);
            return;
        end
        case (nav_phase)
            NAV_SCAN: begin
                if (echo_scaled < 58 * cfg_collision) begin
                    nav_phase = NAV_LOOK_LEFT;
                    push_move(ANGLE_LOOK_L, CMD_STOP, cfg_look_settle, 1'b1, 1'b1);
                end else begin
                    nav_slot = nav_slot + 2'd1;
                    push_move(slot_angle(nav_slot), CMD_FWD, cfg_scan_settle, 1'b1, 1'b1);
                end
            end
            NAV_LOOK_LEFT: begin
                left_count = count;
                nav_phase  = NAV_LOOK_RIGHT;
                push_move(ANGLE_LOOK_R, CMD_STOP, cfg_look_settle, 1'b1, 1'b1);
            end
            NAV_LOOK_RIGHT: begin
                // a tie turns right
                turn_left_q = (left_count > count);
                turn_cmd    = turn_left_q ? CMD_LEFT : CMD_RIGHT;
                nav_phase   = NAV_TURNING;
                push_move(ANGLE_CENTER, CMD_STOP, cfg_scan_settle, 1'b0, 1'b0);
                push_move(ANGLE_CENTER, turn_cmd, '0, 1'b1, 1'b1);
            end
            NAV_TURNING: begin
                turn_cmd = turn_left_q ? CMD_LEFT : CMD_RIGHT;
                if (echo_scaled < 58 * (cfg_collision + cfg_margin)) begin
                    push_move(ANGLE_CENTER, turn_cmd, '0, 1'b1, 1'b1);
                end else begin
                    nav_phase = NAV_SCAN;
                    nav_slot  = '0;
                    push_move(ANGLE_CENTER, CMD_STOP, '0, 1'b0, 1'b0);
                    push_move(ANGLE_CENTER, CMD_FWD, cfg_scan_settle, 1'b1, 1'b1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fault_count++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // echo counts: random, or around the close and clear boundaries of the current settings
    function automatic logic [CountW-1:0] pick_count();
        int c;
        case ($urandom_range(0, 3))
            0: c = $urandom_range(0, 255);
            1: c = (58 * cfg_collision + 63) / 64 + $urandom_range(0, 4) - 2;
            2: c = (58 * (cfg_collision + cfg_margin) + 63) / 64 + $urandom_range(0, 4) - 2;
            default: c = $urandom_range(0, 40);
        endcase
        if (c < 0) c = 0;
        if (c > 255) c = 255;
        return CountW'(c);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_motion(s_req_type, s_echo_count);
                words_taken++;
            end
            if (s_valid && !s_ready) begin
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (outgoing_words.size() > 0) begin
                next_word    = outgoing_words.pop_front();
                s_valid      <= 1'b1;
                s_req_type   <= next_word.req;
                s_echo_count <= next_word.count;
                send_gap     <= steady ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                if (expected_moves.size() == 0) begin
                    $error("result word with nothing expected");
                    fault_count++;
                end else begin
                    want_move = expected_moves.pop_front();
                    check_field("servo_angle", $signed(want_move.servo_angle),
                                $signed(m_servo_angle));
                    check_field("motor_cmd", want_move.motor_cmd, m_motor_cmd);
                    check_field("motor_duty", want_move.motor_duty, m_motor_duty);
                    check_field("wait_ms", want_move.wait_ms, m_wait_ms);
                    check_field("do_measure", want_move.do_measure, m_do_measure);
                    check_field("last_of_run", want_move.last_of_run, m_last_of_run);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (stall_served != stall_requests) begin
                stall_served <= stall_requests;
                stall_left   <= 400;
                m_ready      <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready  <= 1'b1;
                recv_gap <= (steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic offer(input logic req, input int count);
        sonar_word_t w;
        w.req   = req;
        w.count = CountW'(count);
        outgoing_words.push_back(w);
        words_queued++;
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CfgDataW'(value);
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COLLISION:   cfg_collision   = CollisionW'(value);
            REG_MARGIN:      cfg_margin      = MarginW'(value);
            REG_SCAN_SETTLE: cfg_scan_settle = WaitW'(value);
            REG_LOOK_SETTLE: cfg_look_settle = WaitW'(value);
            REG_DRIVE_DUTY:  cfg_duty        = DutyW'(value);
            default: begin
            end
        endcase
    endtask

    task automatic load_settings(input int col, input int margin, input int scan,
                                 input int look, input int duty);
        write_reg(REG_COLLISION, col);
        write_reg(REG_MARGIN, margin);
        write_reg(REG_SCAN_SETTLE, scan);
        write_reg(REG_LOOK_SETTLE, look);
        write_reg(REG_DRIVE_DUTY, duty);
    endtask

    task automatic load_random_settings();
        load_settings($urandom_range(0, 300), $urandom_range(0, 255), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 255));
    endtask

    task automatic queue_random_words(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 29) == 0) offer(REQ_START, $urandom_range(0, 255));
            else offer(REQ_ECHO, pick_count());
        end
    endtask

    // an echo while idle gives no result, so wait for words taken, not only for results
    task automatic wait_quiet();
        while (words_taken != words_queued || expected_moves.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // echoes while idle are dropped
        offer(REQ_ECHO, 100);
        offer(REQ_ECHO, 0);
        offer(REQ_START, 255);
        // far echoes walk the scan slots and wrap, then close echoes run looks and turns
        offer(REQ_ECHO, 19);
        offer(REQ_ECHO, 255);
        offer(REQ_ECHO, 200);
        offer(REQ_ECHO, 100);
        offer(REQ_ECHO, 18);
        offer(REQ_ECHO, 255);
        offer(REQ_ECHO, 0);
        offer(REQ_ECHO, 36);
        offer(REQ_ECHO, 37);
        offer(REQ_ECHO, 0);
        offer(REQ_ECHO, 10);
        offer(REQ_ECHO, 10);
        offer(REQ_ECHO, 255);
        offer(REQ_ECHO, 5);
        offer(REQ_ECHO, 0);
        offer(REQ_ECHO, 255);
        offer(REQ_ECHO, 0);
        // start in the middle of an avoidance
        offer(REQ_START, 77);
        offer(REQ_ECHO, 18);
        offer(REQ_ECHO, 1);
        offer(REQ_START, 3);
        offer(REQ_ECHO, 255);
        wait_quiet();

        load_settings(20, 20, 200, 500, 128);
        queue_random_words(165);
        stall_requests++;
        wait_quiet();

        load_settings(0, 0, 0, 0, 0);
        queue_random_words(165);
        wait_quiet();

        load_settings(511, 255, 1023, 1023, 255);
        queue_random_words(165);
        wait_quiet();

        load_settings(300, 0, 1, 1023, 1);
        queue_random_words(165);
        wait_quiet();

        // back to back with no gaps on either side
        steady = 1'b1;
        load_random_settings();
        queue_random_words(165);
        wait_quiet();
        steady = 1'b0;

        for (int k = 0; k < 3; k++) begin
            load_random_settings();
            queue_random_words(165);
            wait_quiet();
        end

        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
